// ----- sv/assert_macros.svh -----
// Assertion macros used by the allocator engine.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define FFRA_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Condition that must never hold at a clock edge.
`define FFRA_ASSERT_NEVER(label, clk, rstn, cond, msg) \
    `FFRA_ASSERT(label, clk, rstn, !(cond), msg)

`endif

// ----- sv/ffra_pkg.sv -----
// Package for the first-fit run allocator: widths, action codes,
// engine states and the command/response beat types. No dependencies.
package ffra_pkg;

    localparam int SLOT_COUNT_DEF = 2048;
    localparam int WORD_BITS      = 16;
    localparam int WORD_IDX_W     = $clog2(WORD_BITS);
    localparam int LEN_W          = 12;
    localparam int IDX_W          = 11;

    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_DONE
    } ffra_state_t;

    typedef struct packed {
        logic             action;
        logic [LEN_W-1:0] run_length;
        logic [IDX_W-1:0] start_index;
    } ffra_cmd_t;

    typedef struct packed {
        logic             granted;
        logic [IDX_W-1:0] base_index;
    } ffra_rsp_t;

endpackage

// ----- sv/ffra_map_ram.sv -----
// Free map storage: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
module ffra_map_ram #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7,
    parameter int DATA_W = 16
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/ffra_engine.sv -----
// Allocator sequencer: clearing pass, word-wise first-fit scan and
// read-modify-write marking of the free map. Uses ffra_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ffra_engine #(
    parameter int SLOT_COUNT = ffra_pkg::SLOT_COUNT_DEF,
    parameter int WORDS      = 128,
    parameter int WA_W       = 7
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  ffra_pkg::ffra_cmd_t                 cmd,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output ffra_pkg::ffra_rsp_t                 rsp,
    output logic                                rd_en,
    output logic [WA_W-1:0]                     rd_addr,
    input  logic [ffra_pkg::WORD_BITS-1:0]      rd_data,
    output logic                                wr_en,
    output logic [WA_W-1:0]                     wr_addr,
    output logic [ffra_pkg::WORD_BITS-1:0]      wr_data
);
    import ffra_pkg::*;

    localparam int CNT_W     = $clog2(SLOT_COUNT + 1);
    localparam int EXT_W     = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 2;
    localparam int LAST_BITS = SLOT_COUNT - WORD_BITS * (WORDS - 1);
    localparam logic [WA_W-1:0] LAST_WORD = WA_W'(WORDS - 1);

    ffra_state_t state_reg, state_next;

    logic [WA_W-1:0]  cur_reg, cur_next;
    logic [EXT_W-1:0] carry_reg, carry_next;
    logic [EXT_W-1:0] len_reg, len_next;
    logic [EXT_W-1:0] lo_reg, lo_next;
    logic [EXT_W-1:0] hi_reg, hi_next;
    logic             act_reg, act_next;
    logic             granted_reg, granted_next;
    logic [IDX_W-1:0] base_reg, base_next;

    // request decode
    logic             req_alloc;
    logic             req_release_ok;
    logic [EXT_W-1:0] req_len;
    logic [EXT_W-1:0] req_start;
    logic [WA_W-1:0]  req_start_word;

    // scan of the word on the read port
    logic [EXT_W-1:0]      run_len [WORD_BITS];
    logic [WORD_BITS-1:0]  hit;
    logic                  found;
    logic [WORD_IDX_W-1:0] hit_pos;
    logic [EXT_W-1:0]      scan_end;
    logic [EXT_W-1:0]      scan_base;
    logic [WA_W-1:0]       scan_base_word;

    logic [WA_W-1:0]      hi_word;
    logic [WORD_BITS-1:0] mark_word;
    logic [WORD_BITS-1:0] clear_word;

    assign req_len        = EXT_W'(cmd.run_length);
    assign req_start      = EXT_W'(cmd.start_index);
    assign req_alloc      = (cmd.action == ACT_ALLOC) && (cmd.run_length != '0);
    assign req_release_ok = (cmd.action == ACT_RELEASE) && (cmd.run_length != '0)
                            && (req_start + req_len <= EXT_W'(SLOT_COUNT));
    assign req_start_word = WA_W'(req_start >> WORD_IDX_W);

    // Free run ending at each bit: back to the nearest occupied bit, or
    // through the whole word plus the run carried in from below.
    always_comb begin
        logic                  zero_seen;
        logic [WORD_IDX_W-1:0] last_zero;
        for (int p = 0; p < WORD_BITS; p++) begin
            zero_seen = 1'b0;
            last_zero = '0;
            for (int j = 0; j < WORD_BITS; j++) begin
                if (j <= p && !rd_data[j]) begin
                    zero_seen = 1'b1;
                    last_zero = WORD_IDX_W'(j);
                end
            end
            run_len[p] = zero_seen ? (EXT_W'(p) - EXT_W'(last_zero))
                                   : (carry_reg + EXT_W'(p + 1));
            hit[p] = (run_len[p] >= len_reg);
        end
    end

    always_comb begin
        hit_pos = '0;
        for (int p = WORD_BITS - 1; p >= 0; p--) begin
            if (hit[p]) begin
                hit_pos = WORD_IDX_W'(p);
            end
        end
    end

    assign found          = |hit;
    assign scan_end       = EXT_W'({cur_reg, hit_pos});
    assign scan_base      = scan_end + EXT_W'(1) - len_reg;
    assign scan_base_word = WA_W'(scan_base >> WORD_IDX_W);
    assign hi_word        = WA_W'(hi_reg >> WORD_IDX_W);

    // Set or clear the bits of the current word that fall in the run.
    always_comb begin
        logic [EXT_W-1:0] slot;
        for (int b = 0; b < WORD_BITS; b++) begin
            slot = EXT_W'({cur_reg, WORD_IDX_W'(b)});
            if (slot >= lo_reg && slot <= hi_reg) begin
                mark_word[b] = (act_reg == ACT_RELEASE);
            end else begin
                mark_word[b] = rd_data[b];
            end
        end
    end

    // Slots past the end of the pool in the last word stay occupied.
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            clear_word[b] = (cur_reg != LAST_WORD) || (b < LAST_BITS);
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (cur_reg == LAST_WORD) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (cmd_valid) begin
                    if (req_alloc) begin
                        state_next = ST_SCAN;
                    end else if (req_release_ok) begin
                        state_next = ST_MARK;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (found) begin
                    state_next = ST_MARK;
                end else if (cur_reg == LAST_WORD) begin
                    state_next = ST_DONE;
                end
            end
            ST_MARK: begin
                if (cur_reg == hi_word) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (rsp_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd_ready = 1'b0;
        rsp_valid = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = '0;
        wr_en     = 1'b0;
        wr_addr   = cur_reg;
        wr_data   = mark_word;
        unique case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_data = clear_word;
            end
            ST_IDLE: begin
                cmd_ready = 1'b1;
                rd_en     = cmd_valid && (req_alloc || req_release_ok);
                rd_addr   = req_alloc ? '0 : req_start_word;
            end
            ST_SCAN: begin
                if (found) begin
                    rd_en   = 1'b1;
                    rd_addr = scan_base_word;
                end else begin
                    rd_en   = (cur_reg != LAST_WORD);
                    rd_addr = WA_W'(cur_reg + 1'b1);
                end
            end
            ST_MARK: begin
                wr_en   = 1'b1;
                rd_en   = (cur_reg != hi_word);
                rd_addr = WA_W'(cur_reg + 1'b1);
            end
            ST_DONE: begin
                rsp_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        cur_next     = cur_reg;
        carry_next   = carry_reg;
        len_next     = len_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        act_next     = act_reg;
        granted_next = granted_reg;
        base_next    = base_reg;
        case (state_reg)
            ST_CLEAR: begin
                cur_next = WA_W'(cur_reg + 1'b1);
            end
            ST_IDLE: begin
                cur_next     = req_alloc ? '0 : req_start_word;
                carry_next   = '0;
                len_next     = req_len;
                lo_next      = req_start;
                hi_next      = req_start + req_len - EXT_W'(1);
                act_next     = cmd.action;
                granted_next = req_release_ok;
                base_next    = req_release_ok ? cmd.start_index : '0;
            end
            ST_SCAN: begin
                carry_next = run_len[WORD_BITS-1];
                if (found) begin
                    cur_next     = scan_base_word;
                    lo_next      = scan_base;
                    hi_next      = scan_end;
                    granted_next = 1'b1;
                    base_next    = IDX_W'(scan_base);
                end else begin
                    cur_next = WA_W'(cur_reg + 1'b1);
                end
            end
            ST_MARK: begin
                cur_next = WA_W'(cur_reg + 1'b1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            cur_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
        end
    end

    always_ff @(posedge aclk) begin
        carry_reg   <= carry_next;
        len_reg     <= len_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        act_reg     <= act_next;
        granted_reg <= granted_next;
        base_reg    <= base_next;
    end

    assign rsp.granted    = granted_reg;
    assign rsp.base_index = base_reg;

    `FFRA_ASSERT_NEVER(a_no_rw_same_word, aclk, aresetn,
        rd_en && wr_en && (rd_addr == wr_addr), "read and write hit one word")
    `FFRA_ASSERT(a_start_leaves_idle, aclk, aresetn,
        cmd_valid && cmd_ready |=> state_reg != ST_IDLE, "accepted beat left idle")
    `FFRA_ASSERT(a_mark_in_run, aclk, aresetn,
        state_reg == ST_MARK |-> cur_reg <= hi_word, "marking past end of run")
    `FFRA_ASSERT(a_fail_base_zero, aclk, aresetn,
        rsp_valid && !rsp.granted |-> rsp.base_index == '0, "failed beat with base")

endmodule

// ----- sv/first_fit_run_allocator_unit.sv -----
// Top level of the first-fit run allocator: engine, free map memory and
// result register. Uses ffra_pkg, ffra_map_ram and ffra_engine.
//
//  channel | ports                                     | direction
//  --------+-------------------------------------------+----------
//  request | s_valid s_ready s_action s_run_length      | in
//          | s_start_index                             |
//  result  | m_valid m_ready m_granted m_base_index     | out
//
// The free map is held as WORDS words of 16 slots in one memory.
// Allocate: a first-fit scan, one word a cycle, then a read-modify-write
// of each word in the run, between the accepting cycle and the hand-over to
// the result register.
// Release: the marking of each word the run touches, with the same steps around it.
// After reset a clearing pass over every word holds s_ready low.
// A waiting result sits in the output register; the next request may run
// meanwhile and only stalls at its own result.
module first_fit_run_allocator_unit #(
    parameter int SLOT_COUNT = ffra_pkg::SLOT_COUNT_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_action,
    input  logic [ffra_pkg::LEN_W-1:0]  s_run_length,
    input  logic [ffra_pkg::IDX_W-1:0]  s_start_index,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_granted,
    output logic [ffra_pkg::IDX_W-1:0]  m_base_index
);
    import ffra_pkg::*;

    localparam int WORDS = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;

    ffra_cmd_t cmd;
    ffra_rsp_t rsp;
    logic      rsp_valid;
    logic      rsp_ready;

    logic                 rd_en;
    logic [WA_W-1:0]      rd_addr;
    logic [WORD_BITS-1:0] rd_data;
    logic                 wr_en;
    logic [WA_W-1:0]      wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    logic             m_valid_reg, m_valid_next;
    logic             m_granted_reg;
    logic [IDX_W-1:0] m_base_reg;

    assign cmd.action      = s_action;
    assign cmd.run_length  = s_run_length;
    assign cmd.start_index = s_start_index;

    ffra_engine #(
        .SLOT_COUNT(SLOT_COUNT),
        .WORDS     (WORDS),
        .WA_W      (WA_W)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd_valid(s_valid),
        .cmd_ready(s_ready),
        .cmd      (cmd),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    ffra_map_ram #(
        .DEPTH (WORDS),
        .ADDR_W(WA_W),
        .DATA_W(WORD_BITS)
    ) u_map_ram (
        .aclk   (aclk),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data)
    );

    // Load a fresh result when the register is empty or being drained.
    assign rsp_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (rsp_valid && rsp_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rsp_valid && rsp_ready) begin
            m_granted_reg <= rsp.granted;
            m_base_reg    <= rsp.base_index;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_granted    = m_granted_reg;
    assign m_base_index = m_base_reg;

endmodule

// ----- tb/first_fit_run_allocator_unit_tb.sv -----
// Self-checking bench for first_fit_run_allocator_unit: directed and random allocate and
// release beats, checked against a first-fit free map tracker. Depends on ffra_pkg and the unit.
`timescale 1ns / 1ps

module first_fit_run_allocator_unit_tb;
    import ffra_pkg::*;

    localparam int POOL_SLOTS     = SLOT_COUNT_DEF;
    localparam int QUIET_LIMIT    = 5000;
    localparam int HOLD_OFF_BEATS = 1500;
    localparam int SETTLE_CYCLES  = 300;
    localparam int PHASE_ITEMS    = 200;

    typedef struct {
        int unsigned first;
        int unsigned count;
    } run_t;

    // First-fit image of the free map; predicts each grant and checks it on return.
    class free_map_tracker;
        bit [POOL_SLOTS-1:0] free_slots;
        ffra_rsp_t           grants_due[$];
        int                  errors;

        function new();
            free_slots = '1;
            errors = 0;
        endfunction

        function ffra_rsp_t predict_grant(ffra_cmd_t cmd);
            ffra_rsp_t   rsp;
            int unsigned len;
            int unsigned origin;
            int unsigned probe;
            bit          found;
            rsp = '0;
            len = cmd.run_length;
            found = 1'b0;
            origin = 0;
            if (cmd.action == ACT_ALLOC) begin
                if (len != 0) begin
                    while (!found && origin + len <= POOL_SLOTS) begin
                        probe = 0;
                        while (probe < len && free_slots[origin + probe])
                            probe++;
                        // skip past the occupied slot that stopped the probe
                        if (probe >= len)
                            found = 1'b1;
                        else
                            origin += probe + 1;
                    end
                end
                if (found) begin
                    for (int unsigned k = 0; k < len; k++)
                        free_slots[origin + k] = 1'b0;
                    rsp.granted = 1'b1;
                    rsp.base_index = IDX_W'(origin);
                end
            end else begin
                origin = cmd.start_index;
                if (len != 0 && origin + len <= POOL_SLOTS) begin
                    for (int unsigned k = 0; k < len; k++)
                        free_slots[origin + k] = 1'b1;
                    rsp.granted = 1'b1;
                    rsp.base_index = cmd.start_index;
                end
            end
            grants_due.push_back(rsp);
            return rsp;
        endfunction

        function void check_grant(logic granted, logic [IDX_W-1:0] base_index);
            ffra_rsp_t want;
            if (grants_due.size() == 0) begin
                $error("unexpected result beat: granted %0b base_index %0d",
                       granted, base_index);
                errors++;
                return;
            end
            want = grants_due.pop_front();
            if (granted !== want.granted) begin
                $error("granted: expected %0b, actual %0b", want.granted, granted);
                errors++;
            end
            if (base_index !== want.base_index) begin
                $error("base_index: expected %0d, actual %0d", want.base_index, base_index);
                errors++;
            end
        endfunction
    endclass

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic             s_action = ACT_ALLOC;
    logic [LEN_W-1:0] s_run_length = '0;
    logic [IDX_W-1:0] s_start_index = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic             m_granted;
    logic [IDX_W-1:0] m_base_index;

    int               idle_pct = 0;
    int               stall_pct = 0;
    logic             hold_request = 1'b0;
    int               hold_cycles = 0;
    int               quiet_cycles = 0;

    free_map_tracker  tracker = new();
    run_t             held_runs[$];

    first_fit_run_allocator_unit #(
        .SLOT_COUNT(POOL_SLOTS)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_action(s_action),
        .s_run_length(s_run_length),
        .s_start_index(s_start_index),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_granted(m_granted),
        .m_base_index(m_base_index)
    );

    always #10 aclk = ~aclk;

    // Result side: check each beat, stall at random, honour a long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                tracker.check_grant(m_granted, m_base_index);
            if (hold_request) begin
                hold_cycles = HOLD_OFF_BEATS;
                hold_request <= 1'b0;
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one request beat and hold it until accepted; track allocated runs that were granted.
    task automatic issue(input logic act, input int unsigned len, input int unsigned start);
        ffra_cmd_t cmd;
        ffra_rsp_t due;
        run_t      run;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        cmd.action = act;
        cmd.run_length = LEN_W'(len);
        cmd.start_index = IDX_W'(start);
        s_valid <= 1'b1;
        s_action <= cmd.action;
        s_run_length <= cmd.run_length;
        s_start_index <= cmd.start_index;
        do @(posedge aclk); while (!s_ready);
        due = tracker.predict_grant(cmd);
        if (act == ACT_ALLOC && due.granted) begin
            run.first = due.base_index;
            run.count = len;
            held_runs.push_back(run);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (tracker.grants_due.size() != 0)
            @(posedge aclk);
    endtask

    function automatic int unsigned pick_alloc_length();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 4)
            return 0;
        if (roll < 8)
            return $urandom_range(4095, POOL_SLOTS + 1);
        if (roll < 15)
            return $urandom_range(POOL_SLOTS, 257);
        if (roll < 35)
            return $urandom_range(256, 33);
        return $urandom_range(32, 1);
    endfunction

    task automatic random_request();
        int unsigned roll;
        int unsigned slot;
        run_t        run;
        roll = $urandom_range(99);
        if (roll == 0) begin
            // wipe the whole pool now and then so fragmentation starts afresh
            held_runs.delete();
            issue(ACT_RELEASE, POOL_SLOTS, 0);
        end else if (roll < (held_runs.size() > 30 ? 70 : 40)) begin
            if (held_runs.size() > 0 && $urandom_range(99) < 85) begin
                slot = $urandom_range(held_runs.size() - 1);
                run = held_runs[slot];
                held_runs.delete(slot);
                issue(ACT_RELEASE, run.count, run.first);
            end else if ($urandom_range(1)) begin
                issue(ACT_RELEASE, $urandom_range(64), $urandom_range(POOL_SLOTS - 1));
            end else begin
                issue(ACT_RELEASE, $urandom_range(4095), $urandom_range(POOL_SLOTS - 1));
            end
        end else begin
            issue(ACT_ALLOC, pick_alloc_length(), $urandom_range(POOL_SLOTS - 1));
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: degenerate lengths, full pool, overruns, holes and first-fit reuse.
        issue(ACT_ALLOC, 0, 0);
        issue(ACT_ALLOC, 4095, 2047);
        issue(ACT_ALLOC, POOL_SLOTS + 1, 0);
        issue(ACT_ALLOC, POOL_SLOTS, 2047);
        issue(ACT_ALLOC, 1, 0);
        issue(ACT_RELEASE, 2, 2047);
        issue(ACT_RELEASE, 0, 0);
        issue(ACT_RELEASE, 4095, 0);
        issue(ACT_RELEASE, POOL_SLOTS, 0);
        issue(ACT_RELEASE, 1, 2047);
        issue(ACT_ALLOC, 1, 1365);
        issue(ACT_ALLOC, 16, 682);
        issue(ACT_ALLOC, 5, 0);
        issue(ACT_ALLOC, POOL_SLOTS - 22, 0);
        issue(ACT_RELEASE, 16, 1);
        issue(ACT_ALLOC, 3, 0);
        issue(ACT_ALLOC, 14, 0);
        issue(ACT_ALLOC, 13, 0);
        issue(ACT_RELEASE, 1024, 1024);
        issue(ACT_ALLOC, 1025, 0);
        issue(ACT_ALLOC, 1024, 0);
        issue(ACT_RELEASE, POOL_SLOTS, 0);
        issue(ACT_ALLOC, 1, 2047);
        issue(ACT_RELEASE, 1, 0);
        held_runs.delete();
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    idle_pct <= 0;
                    stall_pct <= 0;
                end
                1: begin
                    idle_pct <= 66;
                    stall_pct <= 0;
                end
                2: begin
                    idle_pct <= 0;
                    stall_pct <= 66;
                    // hold the result side off while requests keep coming
                    hold_request <= 1'b1;
                end
                default: begin
                    idle_pct <= 10;
                    stall_pct <= 10;
                end
            endcase
            repeat (PHASE_ITEMS)
                random_request();
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (tracker.errors == 0 && tracker.grants_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- first_fit_run_allocator_unit.f -----
+incdir+sv
sv/ffra_pkg.sv
sv/ffra_map_ram.sv
sv/ffra_engine.sv
sv/first_fit_run_allocator_unit.sv
tb/first_fit_run_allocator_unit_tb.sv
